### hw/rtl/bisync_receive_deframe_crc16_macros.svh
// Assertion macros used by the checker file.
`ifndef BISYNC_RECEIVE_DEFRAME_CRC16_MACROS_SVH
`define BISYNC_RECEIVE_DEFRAME_CRC16_MACROS_SVH

// Checked on every rising clock edge outside reset.
`define BDC16_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("bdc16 check failed");

// Checked on every rising clock edge, reset included.
`define BDC16_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("bdc16 check failed");

`endif

### hw/rtl/bdc16_pkg.sv
package bdc16_pkg;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_HDR,
        PH_BODY,
        PH_CRCLO,
        PH_CRCHI
    } t_phase;

    localparam logic [15:0] CRC_POLY = 16'hA001;

    localparam logic [1:0] CFG_CRC_EN = 2'd0;
    localparam logic [1:0] CFG_DLE    = 2'd1;
    localparam logic [1:0] CFG_ETB    = 2'd2;

    localparam logic       RST_CRC_EN = 1'b1;
    localparam logic [7:0] RST_DLE    = 8'h10;
    localparam logic [7:0] RST_ETB    = 8'h26;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_MISMATCH = 2'd1;
    localparam logic [1:0] ST_UNTERM   = 2'd2;

    localparam logic KIND_DATA   = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    typedef struct packed {
        logic       crc_check_enable;
        logic [7:0] dle_code;
        logic [7:0] etb_code;
    } t_cfg;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       frame_start;
        logic       buffer_end;
    } t_in;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic        kind;
        logic [1:0]  block_status;
        logic [15:0] computed_crc;
    } t_res;

endpackage

### hw/rtl/bdc16_crc.sv
module bdc16_crc (
    input  logic [15:0] i_crc,
    input  logic [7:0]  i_byte,
    output logic [15:0] o_crc
);

    always_comb begin
        logic [15:0] v;
        v = i_crc ^ {8'h00, i_byte};
        for (int k = 0; k < 8; k++) begin
            if (v[0]) begin
                v = (v >> 1) ^ bdc16_pkg::CRC_POLY;
            end else begin
                v = v >> 1;
            end
        end
        o_crc = v;
    end

endmodule

### hw/rtl/bdc16_deframe.sv
module bdc16_deframe (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_adv,
    input  bdc16_pkg::t_in    i_item,
    input  bdc16_pkg::t_cfg   i_cfg,
    output logic              o_res_valid,
    output bdc16_pkg::t_res   o_res
);

    bdc16_pkg::t_phase r_phase, n_phase;
    logic              r_dle, n_dle;
    logic [15:0]       r_crc, n_crc;
    logic [7:0]        r_low, n_low;
    logic [15:0]       crc_next;

    logic        is_dle;
    logic        lone;
    logic        keep;
    logic        term;
    logic        emit_st;
    logic [1:0]  status;

    bdc16_crc u_crc (
        .i_crc  (r_crc),
        .i_byte (i_item.rx_byte),
        .o_crc  (crc_next)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= bdc16_pkg::PH_IDLE;
            r_dle   <= 1'b0;
            r_crc   <= '0;
            r_low   <= '0;
        end else if (i_adv) begin
            r_phase <= n_phase;
            r_dle   <= n_dle;
            r_crc   <= n_crc;
            r_low   <= n_low;
        end
    end

    always_comb begin
        n_phase     = r_phase;
        n_dle       = r_dle;
        n_crc       = r_crc;
        n_low       = r_low;
        emit_st     = 1'b0;
        status      = bdc16_pkg::ST_OK;
        o_res_valid = 1'b0;
        o_res       = '0;
        is_dle      = (i_item.rx_byte == i_cfg.dle_code);
        lone        = is_dle && !r_dle;
        keep        = !(is_dle && r_dle);
        term        = r_dle && (i_item.rx_byte == i_cfg.etb_code);

        if (i_item.frame_start) begin
            n_phase = bdc16_pkg::PH_HDR;
            n_dle   = 1'b0;
            n_crc   = '0;
            n_low   = '0;
            if (i_item.buffer_end) begin
                emit_st = 1'b1;
                status  = bdc16_pkg::ST_UNTERM;
            end
        end else begin
            unique case (r_phase)
                bdc16_pkg::PH_HDR: begin
                    n_phase = bdc16_pkg::PH_BODY;
                    if (i_item.buffer_end) begin
                        emit_st = 1'b1;
                        status  = bdc16_pkg::ST_UNTERM;
                    end
                end
                bdc16_pkg::PH_BODY: begin
                    if (!lone) begin
                        n_crc = crc_next;
                    end
                    if (term) begin
                        n_dle = 1'b0;
                        if (!i_cfg.crc_check_enable) begin
                            emit_st = 1'b1;
                            status  = bdc16_pkg::ST_OK;
                        end else begin
                            n_phase = bdc16_pkg::PH_CRCLO;
                            if (i_item.buffer_end) begin
                                emit_st = 1'b1;
                                status  = bdc16_pkg::ST_UNTERM;
                            end
                        end
                    end else begin
                        n_dle = lone;
                        if (i_item.buffer_end) begin
                            emit_st = 1'b1;
                            status  = bdc16_pkg::ST_UNTERM;
                        end else if (keep) begin
                            o_res_valid    = 1'b1;
                            o_res.out_byte = i_item.rx_byte;
                            o_res.kind     = bdc16_pkg::KIND_DATA;
                        end
                    end
                end
                bdc16_pkg::PH_CRCLO: begin
                    n_low   = i_item.rx_byte;
                    n_phase = bdc16_pkg::PH_CRCHI;
                    if (i_item.buffer_end) begin
                        emit_st = 1'b1;
                        status  = bdc16_pkg::ST_UNTERM;
                    end
                end
                bdc16_pkg::PH_CRCHI: begin
                    emit_st = 1'b1;
                    status  = ({i_item.rx_byte, r_low} == r_crc) ?
                              bdc16_pkg::ST_OK : bdc16_pkg::ST_MISMATCH;
                end
                bdc16_pkg::PH_IDLE: begin
                    n_phase = bdc16_pkg::PH_IDLE;
                end
                default: begin
                    n_phase = bdc16_pkg::PH_IDLE;
                end
            endcase
        end

        if (emit_st) begin
            n_phase            = bdc16_pkg::PH_IDLE;
            n_dle              = 1'b0;
            o_res_valid        = 1'b1;
            o_res.out_byte     = '0;
            o_res.kind         = bdc16_pkg::KIND_STATUS;
            o_res.block_status = status;
            o_res.computed_crc = n_crc;
        end
    end

endmodule

### hw/rtl/bisync_receive_deframe_crc16.sv
// Receive deframer for transparent BISYNC blocks. One received byte is taken per clock
// cycle while the output is not stalled. An accepted byte waits in the input register
// until the result register is free, and the result register then holds the byte's word
// until the word is taken. The byte-wide CRC-16 update and the deframing state machine
// both sit between those two registers, which sets the rate of one byte per cycle while
// the output does not stall. Each byte gives at most one output word: a kept data byte, or
// an end-of-block status with the accumulated CRC. Configuration writes take effect
// at once and should only be made while no block is in flight.
module bisync_receive_deframe_crc16 (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_rx_byte,
    input  logic        i_frame_start,
    input  logic        i_buffer_end,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_out_byte,
    output logic        o_kind,
    output logic [1:0]  o_block_status,
    output logic [15:0] o_computed_crc,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data
);

    bdc16_pkg::t_cfg r_cfg;
    bdc16_pkg::t_in  r_in;
    logic            r_in_valid;
    bdc16_pkg::t_res r_out;
    logic            r_out_valid;

    logic            out_free;
    logic            adv;
    logic            in_acc;
    logic            res_valid;
    bdc16_pkg::t_res res;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign adv        = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !out_free;
    assign in_acc     = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.crc_check_enable <= bdc16_pkg::RST_CRC_EN;
            r_cfg.dle_code         <= bdc16_pkg::RST_DLE;
            r_cfg.etb_code         <= bdc16_pkg::RST_ETB;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                bdc16_pkg::CFG_CRC_EN: r_cfg.crc_check_enable <= i_cfg_data[0];
                bdc16_pkg::CFG_DLE:    r_cfg.dle_code         <= i_cfg_data;
                bdc16_pkg::CFG_ETB:    r_cfg.etb_code         <= i_cfg_data;
                default:               r_cfg                  <= r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_acc) begin
            r_in_valid <= 1'b1;
        end else if (adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_in.rx_byte     <= i_rx_byte;
            r_in.frame_start <= i_frame_start;
            r_in.buffer_end  <= i_buffer_end;
        end
    end

    bdc16_deframe u_deframe (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_adv       (adv),
        .i_item      (r_in),
        .i_cfg       (r_cfg),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= adv && res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && adv && res_valid) begin
            r_out <= res;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_out_byte     = r_out.out_byte;
    assign o_kind         = r_out.kind;
    assign o_block_status = r_out.block_status;
    assign o_computed_crc = r_out.computed_crc;

endmodule

### hw/rtl/bdc16_checker.sv
`include "bisync_receive_deframe_crc16_macros.svh"

module bdc16_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_stall,
    input logic [7:0]  i_rx_byte,
    input logic        i_frame_start,
    input logic        i_buffer_end,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [7:0]  o_out_byte,
    input logic        o_kind,
    input logic [1:0]  o_block_status,
    input logic [15:0] o_computed_crc,
    input logic        i_cfg_we,
    input logic [1:0]  i_cfg_index,
    input logic [7:0]  i_cfg_data
);

    `BDC16_ASSERT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_byte) && $stable(o_kind) && $stable(o_block_status) && $stable(o_computed_crc))
    `BDC16_ASSERT(a_data_clean, i_clk, i_rst_n, o_out_valid && (o_kind == bdc16_pkg::KIND_DATA) |-> (o_block_status == bdc16_pkg::ST_OK) && (o_computed_crc == 16'h0000))
    `BDC16_ASSERT(a_status_clean, i_clk, i_rst_n, o_out_valid && (o_kind == bdc16_pkg::KIND_STATUS) |-> (o_out_byte == 8'h00) && (o_block_status != 2'd3))
    `BDC16_ASSERT_ALWAYS(a_reset_quiet, i_clk, !i_rst_n |=> !o_out_valid)

endmodule

bind bisync_receive_deframe_crc16 bdc16_checker u_bdc16_checker (.*);
